// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, muted while reset is high.
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Concurrent check that also holds across reset.
`define ASSERT_PROP_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ----- rtl/kfs_pkg.sv -----
package kfs_pkg;

  // Width of the rank, slot and found-slot fields and of the size register.
  localparam int FIELD_W = 11;

  // Operation codes.
  localparam logic FUNC_SELECT = 1'b0;
  localparam logic FUNC_MARK   = 1'b1;

  // Size register value after reset.
  localparam logic [FIELD_W-1:0] ACTIVE_RESET = 11'd1024;

endpackage

// ----- rtl/kth_free_slot_select.sv -----
// K-th free slot finder over a count tree of removed positions 1..SIZE. A select
// request walks the tree from the root, one level per cycle, reading the left
// child count from a single-port-read count memory (registered read data). A mark
// request walks down to the leaf without using the read data, reads the leaf, and
// if the slot is still free walks back up doing a read-modify-write of one
// ancestor per cycle; a mark of an invalid slot goes straight to the finish state.
// One request is in flight at a time; the result register lets a new request in
// while the previous result waits. After reset the count memory is swept to zero,
// one entry per cycle, over all 2**(ceil(log2(SIZE))+1) entries (2048 at
// SIZE=1024); requests are held off during the sweep while size register writes
// are taken as usual.
module kth_free_slot_select #(
  parameter int SIZE = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [kfs_pkg::FIELD_W-1:0]  cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         func,
  input  logic [kfs_pkg::FIELD_W-1:0]  rank,
  input  logic [kfs_pkg::FIELD_W-1:0]  slot,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [kfs_pkg::FIELD_W-1:0]  found_slot,
  output logic                         not_found
);
  import kfs_pkg::*;

  localparam int PW    = $clog2(SIZE + 1);          // position / count width
  localparam int NW    = $clog2(SIZE) + 1;          // tree node index width
  localparam int DEPTH = 2 ** NW;
  localparam int XW    = (PW > FIELD_W) ? PW : FIELD_W;
  localparam logic [PW-1:0] SIZE_P = PW'(SIZE);
  localparam logic [NW-1:0] ROOT   = NW'(1);
  localparam logic [NW-1:0] ROOT_L = NW'(2);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_LEAF  = 3'd3;
  localparam logic [2:0] S_UP    = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]         state;
  logic [NW-1:0]      clr_addr;
  logic [NW-1:0]      node;
  logic [PW-1:0]      lo;
  logic [PW-1:0]      hi;
  logic [FIELD_W-1:0] k;
  logic               op;
  logic [PW-1:0]      target;
  logic               early_bad;
  logic [PW-1:0]      total_removed;
  logic [FIELD_W-1:0] active_size;

  // Count memory: one removed count per tree node.
  logic [PW-1:0] mem [DEPTH];
  logic [PW-1:0] rd_data;
  logic [NW-1:0] rd_addr;
  logic          wr_en;
  logic [NW-1:0] wr_addr;
  logic [PW-1:0] wr_data;

  // Walk step signals.
  logic [PW:0]   span_sum;
  logic [PW-1:0] mid;
  logic [PW-1:0] free_left;
  logic          go_left;
  logic [NW-1:0] node_next;
  logic [PW-1:0] lo_next;
  logic [PW-1:0] hi_next;
  logic [FIELD_W-1:0] k_next;
  logic [XW-1:0] k_diff;
  logic          at_leaf;

  // Accept-time checks.
  logic          accept;
  logic [XW-1:0] slot_x;
  logic          slot_ok;
  logic [PW-1:0] free_total;
  logic          rank_bad;

  // Finish signals.
  logic [XW-1:0] lo_x;
  logic          sel_bad;
  logic          out_load;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state == S_FIN) && (!out_valid || out_ready);

  // Request checks.
  assign slot_x     = XW'(slot);
  assign slot_ok    = (slot != '0) && (slot_x <= XW'(SIZE_P));
  assign free_total = SIZE_P - total_removed;
  assign rank_bad   = (rank == '0) || (XW'(rank) > XW'(free_total));

  // One level of the descent.
  always_comb begin
    span_sum  = {1'b0, lo} + {1'b0, hi};
    mid       = span_sum[PW:1];
    free_left = (mid - lo + PW'(1)) - rd_data;
    k_diff    = XW'(k) - XW'(free_left);
    if (op == FUNC_SELECT) begin
      go_left = (XW'(k) <= XW'(free_left));
    end else begin
      go_left = (target <= mid);
    end
    if (go_left) begin
      node_next = {node[NW-2:0], 1'b0};
      lo_next   = lo;
      hi_next   = mid;
      k_next    = k;
    end else begin
      node_next = {node[NW-2:0], 1'b1};
      lo_next   = mid + PW'(1);
      hi_next   = hi;
      k_next    = k_diff[FIELD_W-1:0];
    end
    at_leaf = (lo_next == hi_next);
  end

  // Read address: left child for select, next node on the path (ending at the leaf) for mark, parent on the way up.
  always_comb begin
    rd_addr = ROOT;
    case (state)
      S_IDLE: rd_addr = ROOT_L;
      S_WALK: begin
        if (op == FUNC_SELECT) begin
          rd_addr = {node_next[NW-2:0], 1'b0};
        end else begin
          rd_addr = node_next;
        end
      end
      S_LEAF, S_UP: rd_addr = node >> 1;
      default: rd_addr = ROOT;
    endcase
  end

  // Write port: clearing sweep or count increment.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = node;
    wr_data = rd_data + PW'(1);
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      S_LEAF:  wr_en = (rd_data == '0);
      S_UP:    wr_en = 1'b1;
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Select outcome.
  assign lo_x    = XW'(lo);
  assign sel_bad = early_bad || (lo_x > XW'(active_size));

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      total_removed <= '0;
      active_size   <= ACTIVE_RESET;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        active_size <= cfg_wdata;
      end
      // A new result loaded in the same cycle keeps valid high.
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + NW'(1);
          if (clr_addr == NW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op        <= func;
            node      <= ROOT;
            lo        <= PW'(1);
            hi        <= SIZE_P;
            k         <= rank;
            target    <= slot_x[PW-1:0];
            early_bad <= rank_bad;
            if (func == FUNC_MARK && !slot_ok) begin
              state <= S_FIN;
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          node <= node_next;
          lo   <= lo_next;
          hi   <= hi_next;
          k    <= k_next;
          if (at_leaf) begin
            state <= (op == FUNC_SELECT) ? S_FIN : S_LEAF;
          end
        end
        S_LEAF: begin
          if (rd_data == '0) begin
            total_removed <= total_removed + PW'(1);
            node          <= node >> 1;
            state         <= S_UP;
          end else begin
            state <= S_FIN;
          end
        end
        S_UP: begin
          if (node == ROOT) begin
            state <= S_FIN;
          end else begin
            node <= node >> 1;
          end
        end
        S_FIN: begin
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (op == FUNC_SELECT && !sel_bad) begin
        found_slot <= lo_x[FIELD_W-1:0];
      end else begin
        found_slot <= '0;
      end
      not_found <= (op == FUNC_SELECT) && sel_bad;
    end
  end

endmodule

// ----- rtl/kfs_checker.sv -----
`include "assert_macros.svh"

module kfs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [kfs_pkg::FIELD_W-1:0] found_slot,
  input logic                        not_found
);
  import kfs_pkg::*;

  // A stalled result holds.
  `ASSERT_PROP(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(found_slot) && $stable(not_found))

  // A miss never carries a position.
  `ASSERT_PROP(a_miss_zero, clk, rst, out_valid && not_found |-> found_slot == '0)

  // One request at a time: ready drops after an accept.
  `ASSERT_PROP(a_one_inflight, clk, rst, in_valid && in_ready |=> !in_ready)

  // Clearing sweep follows reset, so no request is taken right after it.
  `ASSERT_PROP_NR(a_clear_after_rst, clk, rst |=> !in_ready && !out_valid)

endmodule

bind kth_free_slot_select kfs_checker u_kfs_checker (.*);

// ----- sim/tb_kth_free_slot_select.sv -----
module tb_kth_free_slot_select;
  timeunit 1ns;
  timeprecision 1ps;

  import kfs_pkg::*;

  localparam int SLOTS      = 1024;
  localparam int LAST_FIELD = 2**FIELD_W - 1;

  typedef logic [FIELD_W-1:0] field_t;

  typedef struct packed {
    field_t found_slot;
    logic   not_found;
  } slot_answer_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   cfg_we = 1'b0;
  field_t cfg_wdata = '0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  logic   func = FUNC_SELECT;
  field_t rank = '0;
  field_t slot = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  field_t found_slot;
  logic   not_found;

  // Shadow of the block: removed flags per position and the size register
  bit     slot_removed [1:SLOTS];
  field_t size_shadow = ACTIVE_RESET;

  slot_answer_t pending_answers[$];
  int mismatch_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  kth_free_slot_select #(.SIZE(SLOTS)) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .rank(rank),
    .slot(slot),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .found_slot(found_slot),
    .not_found(not_found)
  );

  always #4 clk = ~clk;

  // Searched range, with the register saturated at the store size
  function automatic int searched_span();
    return (size_shadow > SLOTS) ? SLOTS : int'(size_shadow);
  endfunction

  function automatic int free_in_span();
    int n;
    n = 0;
    for (int p = 1; p <= searched_span(); p++)
      if (!slot_removed[p]) n++;
    return n;
  endfunction

  // Expected answer of one request; a mark updates the shadow
  function automatic slot_answer_t predict_answer(logic f, field_t r, field_t s);
    slot_answer_t ans;
    int k;
    ans = '0;
    if (f == FUNC_MARK) begin
      // out-of-range slots are dropped; re-marking is harmless
      if (s >= 1 && s <= SLOTS) slot_removed[s] = 1'b1;
      return ans;
    end
    if (r == 0 || r > free_in_span()) begin
      ans.not_found = 1'b1;
      return ans;
    end
    // rank fits inside the span, so the k-th free overall lies in it
    k = r;
    for (int p = 1; p <= SLOTS; p++) begin
      if (!slot_removed[p]) begin
        k--;
        if (k == 0) begin
          ans.found_slot = field_t'(p);
          break;
        end
      end
    end
    return ans;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Drive one request, hold it until taken, then maybe go idle
  task automatic send_request(logic f, field_t r, field_t s);
    slot_answer_t ans;
    in_valid <= 1'b1;
    func     <= f;
    rank     <= r;
    slot     <= s;
    do @(posedge clk); while (!in_ready);
    ans = predict_answer(f, r, s);
    pending_answers.insert(pending_answers.size(), ans);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_requests();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic write_active_size(field_t v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we      <= 1'b0;
    size_shadow = v;
  endtask

  // Receiver stall
  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= stall_pct);

  // Result check against the oldest pending answer
  always @(posedge clk) begin
    slot_answer_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result with no request pending", found_slot, 0);
      end else begin
        want = pending_answers.pop_front();
        if (found_slot !== want.found_slot)
          report_mismatch("found_slot", found_slot, want.found_slot);
        if (not_found !== want.not_found)
          report_mismatch("not_found", not_found, want.not_found);
      end
    end
  end

  // Full range at its reset size, nothing removed yet
  task automatic test_reset_range();
    send_request(FUNC_SELECT, 11'd1, 11'd0);
    send_request(FUNC_SELECT, 11'd1024, 11'd0);
    send_request(FUNC_SELECT, 11'd1025, 11'd0);
    send_request(FUNC_SELECT, 11'd0, field_t'(LAST_FIELD));
    send_request(FUNC_SELECT, field_t'(LAST_FIELD), 11'd0);
  endtask

  // Marks: normal, repeated, out of range, top slot
  task automatic test_mark_rules();
    send_request(FUNC_MARK, 11'd0, 11'd1);
    send_request(FUNC_MARK, field_t'(LAST_FIELD), 11'd1);
    send_request(FUNC_MARK, 11'd0, 11'd0);
    send_request(FUNC_MARK, 11'd0, field_t'(LAST_FIELD));
    send_request(FUNC_MARK, 11'd0, 11'd1025);
    send_request(FUNC_MARK, 11'd0, 11'd1024);
    send_request(FUNC_SELECT, 11'd1, 11'd0);
    send_request(FUNC_SELECT, 11'd1022, 11'd0);
    send_request(FUNC_SELECT, 11'd1023, 11'd0);
    drain_requests();
  endtask

  // Size register at one, zero, saturated and small
  task automatic test_active_size_limits();
    write_active_size(11'd1);
    send_request(FUNC_SELECT, 11'd1, 11'd0);
    send_request(FUNC_MARK, 11'd0, 11'd700);
    drain_requests();
    write_active_size(11'd0);
    send_request(FUNC_SELECT, 11'd1, 11'd0);
    drain_requests();
    write_active_size(field_t'(LAST_FIELD));
    send_request(FUNC_SELECT, 11'd1021, 11'd0);
    send_request(FUNC_SELECT, 11'd1022, 11'd0);
    drain_requests();
    write_active_size(11'd1025);
    send_request(FUNC_SELECT, 11'd1, 11'd0);
    drain_requests();
    write_active_size(11'd3);
    send_request(FUNC_SELECT, 11'd2, 11'd0);
    send_request(FUNC_SELECT, 11'd3, 11'd0);
    drain_requests();
  endtask

  // Mixed selects and marks, ranks mostly within the live free count
  task automatic test_random_traffic(int count, field_t size, int send_idle, int recv_stall);
    logic   f;
    field_t r;
    field_t s;
    int     free_cnt;
    int     span;
    int     pick;
    write_active_size(size);
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    repeat (count) begin
      free_cnt = free_in_span();
      span     = searched_span();
      f = ($urandom_range(99) < 35) ? FUNC_MARK : FUNC_SELECT;
      pick = $urandom_range(99);
      if (pick < 70 && free_cnt > 0)
        r = field_t'($urandom_range(1, free_cnt));
      else if (pick < 85)
        r = field_t'(free_cnt + $urandom_range(0, 1));
      else
        r = field_t'($urandom_range(0, LAST_FIELD));
      pick = $urandom_range(99);
      if (pick < 55)
        s = field_t'($urandom_range(1, (span > 0) ? span : 1));
      else if (pick < 90)
        s = field_t'($urandom_range(1, SLOTS));
      else if (pick < 95)
        s = '0;
      else
        s = field_t'($urandom_range(SLOTS + 1, LAST_FIELD));
      send_request(f, r, s);
    end
    drain_requests();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_range();
    test_mark_rules();
    test_active_size_limits();
    test_random_traffic(220, 11'd1024, 0, 0);
    test_random_traffic(220, field_t'($urandom_range(2, 1023)), 86, 0);
    test_random_traffic(220, 11'd16, 0, 86);
    test_random_traffic(220, field_t'($urandom_range(1025, LAST_FIELD)), 27, 27);
    test_random_traffic(200, 11'd1, 0, 0);
    test_random_traffic(220, 11'd512, 86, 0);
    test_random_traffic(220, field_t'($urandom_range(2, 1023)), 0, 86);
    test_random_traffic(220, 11'd1024, 27, 27);
    repeat (30) @(posedge clk);
    if (mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
